/* hdl/assert_macros.svh */
// Assertion macros used by the baseline removal top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/mabr_pkg.sv */
// Shared constants and types for the moving-average baseline removal block.
package mabr_pkg;

  localparam int WINDOW_LEN_DEF = 256;
  localparam int SAMPLE_W       = 8;
  localparam int FRAC_W         = 8;
  localparam int MEAN_W         = 16;
  localparam int OUT_W          = 17;
  localparam logic [MEAN_W-1:0] MEAN_MAX = 16'hFF00;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/moving_average_baseline_removal_top.sv */
// Samples enter only in S_IDLE, once the bit-serial divider is done with the one before.
// The ring is read on the beat, the sum updates in S_READ, then one quotient bit a cycle.
// A finished result waits in the output register while the next sample is taken.
// Synchronous reset clears state, pointer, fill count, sum, enable, out_valid; ring stays.
module moving_average_baseline_removal_top #(
  parameter int WINDOW_LEN = mabr_pkg::WINDOW_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               acquire_enable,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mabr_pkg::SAMPLE_W-1:0]      raw_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mabr_pkg::OUT_W-1:0]  centered_sample
);

  localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = $clog2(WINDOW_LEN * 255 + 1);
  localparam int DIV_W = SUM_W + mabr_pkg::FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic                            enable;
  logic [mabr_pkg::SAMPLE_W-1:0]   ring [WINDOW_LEN];
  logic [mabr_pkg::SAMPLE_W-1:0]   old_sample;
  logic [mabr_pkg::SAMPLE_W-1:0]   sample;
  logic [PTR_W-1:0]                wptr;
  logic [CNT_W-1:0]                fill_count;
  logic [SUM_W-1:0]                window_sum;

  logic                            full;
  logic [SUM_W-1:0]                sum_next;
  logic [CNT_W-1:0]                fill_next;
  logic                            in_beat;
  logic                            out_free;
  logic                            div_start;
  logic [mabr_pkg::MEAN_W-1:0]     div_q;
  mabr_pkg::div_stat_t             div_stat;
  logic                            load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign full      = (fill_count == CNT_W'(WINDOW_LEN));
  assign div_start = (state == S_READ);
  assign load_out  = (state == S_DIV) && div_stat.done && out_free;

  // Drop the oldest sample once the window is full.
  assign sum_next  = window_sum - (full ? SUM_W'(old_sample) : '0) + SUM_W'(sample);
  assign fill_next = full ? fill_count : fill_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable <= acquire_enable;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_beat && enable) state_next = S_READ;
      S_READ: state_next = S_DIV;
      S_DIV:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring memory: read the oldest entry on the sample beat, overwrite it in S_READ.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      old_sample <= ring[wptr];
      sample     <= raw_sample;
    end
    if (state == S_READ) begin
      ring[wptr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      fill_count <= '0;
      window_sum <= '0;
    end else if (state == S_READ) begin
      wptr       <= (wptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : wptr + PTR_W'(1);
      fill_count <= fill_next;
      window_sum <= sum_next;
    end
  end

  mabr_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_next, mabr_pkg::FRAC_W'(0)}),
    .divisor  (fill_next),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      centered_sample <= $signed({1'b0, sample, mabr_pkg::FRAC_W'(0)})
                       - $signed({1'b0, div_q});
    end
  end

`include "assert_macros.svh"

  `ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= CNT_W'(WINDOW_LEN))
  `ASSERT_NOW(a_mean_range, div_stat.done, div_q <= mabr_pkg::MEAN_MAX)
  `ASSERT_NEXT(a_enabled_beat_reads, in_beat && enable, state == S_READ)
  `ASSERT_NEXT(a_result_loaded, load_out, out_valid)

endmodule

/* hdl/mabr_div.sv */
// Restoring divider, one quotient bit per cycle, for the window mean.
module mabr_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DIVIDEND_W-1:0]         dividend,
  input  logic [DIVISOR_W-1:0]          divisor,
  output logic [mabr_pkg::MEAN_W-1:0]   quotient,
  output mabr_pkg::div_stat_t           stat
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] acc;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  take;

  assign trial = {rem, acc[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift dividend bits out and quotient bits in through the same register.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= {acc[DIVIDEND_W-2:0], take};
      rem <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient  = acc[mabr_pkg::MEAN_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* dv/mabr_centering_checker.sv */
// Checker for the baseline removal block: tracks the sample window, predicts and compares.
`timescale 1ns / 1ps
module mabr_centering_checker #(
  parameter int WINDOW_LEN = mabr_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic                                acquire_enable,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [mabr_pkg::SAMPLE_W-1:0]       raw_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [mabr_pkg::OUT_W-1:0]   centered_sample,
  output int                                  fail_count,
  output int                                  outstanding
);

  logic [mabr_pkg::SAMPLE_W-1:0]      window_ring [WINDOW_LEN];
  int                                 wr_ptr;
  int                                 held_count;
  int                                 held_sum;
  logic                               enabled;
  logic signed [mabr_pkg::OUT_W-1:0]  centered_q [$];

  // Push one sample into the window and return it minus the floored window mean.
  function automatic logic signed [mabr_pkg::OUT_W-1:0] centre_sample(
      input logic [mabr_pkg::SAMPLE_W-1:0] s);
    longint window_mean;
    longint centred;
    // the oldest entry is only read once the ring is full
    if (held_count >= WINDOW_LEN) begin
      held_sum -= int'(window_ring[wr_ptr]);
    end else begin
      held_count++;
    end
    window_ring[wr_ptr] = s;
    held_sum += int'(s);
    wr_ptr = (wr_ptr == WINDOW_LEN - 1) ? 0 : wr_ptr + 1;
    window_mean = (longint'(held_sum) <<< mabr_pkg::FRAC_W) / longint'(held_count);
    centred = (longint'(s) <<< mabr_pkg::FRAC_W) - window_mean;
    return mabr_pkg::OUT_W'(centred);
  endfunction

  always @(posedge clk) begin
    logic signed [mabr_pkg::OUT_W-1:0] want;
    if (rst) begin
      wr_ptr     = 0;
      held_count = 0;
      held_sum   = 0;
      enabled    = 1'b0;
      centered_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        enabled = acquire_enable;
      end
      // drop samples while acquisition is off
      if (in_valid && in_ready && enabled) begin
        centered_q.push_back(centre_sample(raw_sample));
      end
      if (out_valid && out_ready) begin
        if (centered_q.size() == 0) begin
          $display("%0t: centered_sample expected none, got %0d", $time, centered_sample);
          fail_count++;
        end else begin
          want = centered_q.pop_front();
          if (centered_sample !== want) begin
            $display("%0t: centered_sample expected %0d, got %0d", $time, want,
                     centered_sample);
            fail_count++;
          end
        end
      end
    end
    outstanding <= centered_q.size();
  end

endmodule

/* dv/moving_average_baseline_removal_top_test.sv */
// Test top: drives samples and configuration into the baseline removal block.
`timescale 1ns / 1ps
module moving_average_baseline_removal_top_test;

  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 400000;

  logic                                clk            = 1'b0;
  logic                                rst            = 1'b1;
  logic                                cfg_valid      = 1'b0;
  logic                                cfg_ready;
  logic                                acquire_enable = 1'b0;
  logic                                in_valid       = 1'b0;
  logic                                in_ready;
  logic [mabr_pkg::SAMPLE_W-1:0]       raw_sample     = '0;
  logic                                out_valid;
  logic                                out_ready      = 1'b0;
  logic signed [mabr_pkg::OUT_W-1:0]   centered_sample;
  logic                                calm           = 1'b0;
  int                                  fail_count;
  int                                  outstanding;
  int                                  cycles         = 0;

  logic [mabr_pkg::SAMPLE_W-1:0] corner_samples [15] = '{
    8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFE, 8'h80, 8'h7F,
    8'h55, 8'hAA, 8'h03, 8'h07, 8'hFF, 8'h00, 8'h02
  };

  moving_average_baseline_removal_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .acquire_enable  (acquire_enable),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_sample      (raw_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .centered_sample (centered_sample)
  );

  mabr_centering_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .acquire_enable  (acquire_enable),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_sample      (raw_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .centered_sample (centered_sample),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("moving_average_baseline_removal_top_test failed");
      $finish;
    end
  end

  // Receiver: ready held high or low in bursts, always high once calm.
  always begin
    if (calm || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
    end
    repeat ($urandom_range(1, 10)) @(posedge clk);
  end

  task automatic send_sample(input logic [mabr_pkg::SAMPLE_W-1:0] value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_sample <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold input until every pending result has come, then let the block settle.
  task automatic wait_for_drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_acquire_enable(input logic value);
    cfg_valid      <= 1'b1;
    acquire_enable <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Runs of uniform noise, baseline wander, flat lines and full-swing toggling.
  task automatic send_ecg_stream(input int count);
    int sent;
    int kind;
    int run;
    int base;
    int level;
    logic [mabr_pkg::SAMPLE_W-1:0] v;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      base = $urandom_range(0, 255);
      case (kind) inside
        5:          run = $urandom_range(20, 120);
        [6:7], 9:   run = $urandom_range(1, 300);
        8:          run = $urandom_range(1, 60);
        default:    run = $urandom_range(1, 40);
      endcase
      for (int k = 0; k < run && sent < count; k++) begin
        case (kind)
          5: begin
            level = base + $urandom_range(0, 31) - 16;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            v = level[mabr_pkg::SAMPLE_W-1:0];
          end
          6:       v = 8'hFF;
          7:       v = 8'h00;
          8:       v = k[0] ? 8'hFF : 8'h00;
          9:       v = base[mabr_pkg::SAMPLE_W-1:0];
          default: v = mabr_pkg::SAMPLE_W'($urandom_range(0, 255));
        endcase
        send_sample(v);
        sent++;
      end
    end
  endtask

  initial begin
    do @(posedge clk); while (rst);

    // acquisition is off out of reset: these beats must vanish
    repeat (3) send_sample(mabr_pkg::SAMPLE_W'($urandom_range(0, 255)));
    wait_for_drain(SETTLE_CYCLES);
    write_acquire_enable(1'b0);
    repeat (2) send_sample(mabr_pkg::SAMPLE_W'($urandom_range(0, 255)));
    wait_for_drain(SETTLE_CYCLES);
    write_acquire_enable(1'b1);

    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    send_ecg_stream(400);
    wait_for_drain(0);
    send_ecg_stream(200);

    wait_for_drain(SETTLE_CYCLES);
    write_acquire_enable(1'b0);
    repeat (20) send_sample(mabr_pkg::SAMPLE_W'($urandom_range(0, 255)));
    wait_for_drain(SETTLE_CYCLES);
    write_acquire_enable(1'b1);
    send_ecg_stream(250);

    calm <= 1'b1;
    send_ecg_stream(150);
    wait_for_drain(SETTLE_CYCLES);

    if (fail_count == 0 && outstanding == 0) begin
      $display("moving_average_baseline_removal_top_test passed");
    end else begin
      $display("moving_average_baseline_removal_top_test failed");
    end
    $finish;
  end

endmodule

/* moving_average_baseline_removal_top.f */
+incdir+hdl
hdl/mabr_pkg.sv
hdl/mabr_div.sv
hdl/moving_average_baseline_removal_top.sv
dv/mabr_centering_checker.sv
dv/moving_average_baseline_removal_top_test.sv
